// ----- rtl/pmap_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged mapper package
// Operation codes, page constants and the types shared by the mapper modules.
// ----------------------------------------------------------------------------
package pmap_pkg;

  // Request operation codes.
  localparam logic [1:0] OP_SRAM_WRITE = 2'd0;
  localparam logic [1:0] OP_SRAM_READ  = 2'd1;
  localparam logic [1:0] OP_CONTROL    = 2'd2;
  localparam logic [1:0] OP_TRANSLATE  = 2'd3;

  // Page table geometry (fixed by the logical address split).
  localparam int PAGE_COUNT  = 16;
  localparam int PAGE_BITS   = 4;
  localparam int OFFSET_W    = 32;
  localparam int DISP_W      = 12;

  // Default size of the map file SRAM in bytes.
  localparam int SRAM_BYTES_DEF = 1024;

  // Map file walk: 16 pages of 4 bytes.
  localparam int WALK_BYTES = 64;

  // One result as presented on the output ports.
  typedef struct packed {
    logic                valid;
    logic [7:0]          read_data;
    logic [OFFSET_W-1:0] physical_address;
  } res_t;

  // Access to the page offset RAM.
  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [PAGE_BITS-1:0] idx;
    logic [OFFSET_W-1:0]  wdata;
  } pg_req_t;

endpackage

// ----- rtl/pmap_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged mapper RAM
// Single-port synchronous RAM with a registered read, one access per cycle.
// ----------------------------------------------------------------------------
module pmap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/pmap_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged mapper sequencer
// Takes requests, runs the clearing pass, SRAM accesses, translations and
// the 64-byte map file load and store walks against the two RAMs.
// ----------------------------------------------------------------------------
module pmap_seq
  import pmap_pkg::*;
#(
  parameter int SRAM_BYTES = SRAM_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [1:0]                    op,
  input  logic [15:0]                   addr,
  input  logic [7:0]                    data,
  output logic                          busy,
  output res_t                          res,
  output logic [$clog2(SRAM_BYTES)-1:0] sram_addr,
  output logic                          sram_we,
  output logic                          sram_re,
  output logic [7:0]                    sram_wdata,
  input  logic [7:0]                    sram_rdata,
  output pg_req_t                       pg,
  input  logic [OFFSET_W-1:0]           pg_rdata
);

  localparam int AW = $clog2(SRAM_BYTES);
  localparam logic [AW-1:0] CLR_LAST = AW'(SRAM_BYTES - 1);
  localparam logic [23:0] MODV = 24'(SRAM_BYTES);
  localparam int CW = $clog2(WALK_BYTES + 1);
  localparam logic [CW-1:0] CNT_END = CW'(WALK_BYTES);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_RDW   = 3'd3;
  localparam logic [2:0] ST_XLW   = 3'd4;
  localparam logic [2:0] ST_LOAD  = 3'd5;
  localparam logic [2:0] ST_STORE = 3'd6;

  // Byte offset modulo the SRAM size: the quotient is below 128, so seven
  // compare and subtract steps on a narrow value.
  function automatic logic [AW-1:0] sram_wrap(input logic [15:0] a);
    logic [23:0] x;
    x = {8'd0, a};
    for (int k = 6; k >= 0; k--) begin
      if (x >= (MODV << k)) begin
        x = x - (MODV << k);
      end
    end
    return x[AW-1:0];
  endfunction

  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [15:0]         addr_r, addr_nxt;
  logic [7:0]          data_r, data_nxt;
  logic [23:0]         asm_r, asm_nxt;
  logic [OFFSET_W-1:0] hold_r, hold_nxt;
  res_t                res_r, res_nxt;
  logic [5:0]          widx;
  logic [2:0]          bank;
  logic                accept;

  assign busy   = (state_r != ST_IDLE) || !rst_n;
  assign accept = start && !busy;
  assign widx   = 6'(cnt_r - CW'(1));
  assign bank   = data_r[3:1];
  assign res    = res_r;

  // Control and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      res_r   <= res_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    addr_r <= addr_nxt;
    data_r <= data_nxt;
    asm_r  <= asm_nxt;
    hold_r <= hold_nxt;
  end

  // Sequencer and RAM port control.
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    cnt_nxt    = cnt_r;
    op_nxt     = op_r;
    addr_nxt   = addr_r;
    data_nxt   = data_r;
    asm_nxt    = asm_r;
    hold_nxt   = hold_r;
    res_nxt    = res_r;
    res_nxt.valid = 1'b0;
    sram_addr  = '0;
    sram_we    = 1'b0;
    sram_re    = 1'b0;
    sram_wdata = '0;
    pg         = '0;

    case (state_r)
      // Zero both RAMs, one SRAM byte per cycle.
      ST_CLEAR: begin
        sram_addr = clr_r;
        sram_we   = 1'b1;
        pg.we     = 1'b1;
        pg.idx    = clr_r[PAGE_BITS-1:0];
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          op_nxt    = op;
          addr_nxt  = addr;
          data_nxt  = data;
          state_nxt = ST_EXEC;
        end
      end

      // First cycle of a request: issue the RAM access, start a walk or end an ignored control write.
      ST_EXEC: begin
        res_nxt.read_data        = '0;
        res_nxt.physical_address = '0;
        cnt_nxt                  = '0;
        case (op_r)
          OP_SRAM_WRITE: begin
            sram_addr     = sram_wrap(addr_r);
            sram_we       = 1'b1;
            sram_wdata    = data_r;
            res_nxt.valid = 1'b1;
            state_nxt     = ST_IDLE;
          end
          OP_SRAM_READ: begin
            sram_addr = sram_wrap(addr_r);
            sram_re   = 1'b1;
            state_nxt = ST_RDW;
          end
          OP_CONTROL: begin
            if (data_r[7:4] != 4'd0) begin
              res_nxt.valid = 1'b1;
              state_nxt     = ST_IDLE;
            end else if (data_r[0]) begin
              state_nxt = ST_LOAD;
            end else begin
              state_nxt = ST_STORE;
            end
          end
          OP_TRANSLATE: begin
            pg.re     = 1'b1;
            pg.idx    = addr_r[15:12];
            state_nxt = ST_XLW;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_RDW: begin
        res_nxt.valid     = 1'b1;
        res_nxt.read_data = sram_rdata;
        state_nxt         = ST_IDLE;
      end

      ST_XLW: begin
        res_nxt.valid            = 1'b1;
        res_nxt.physical_address = pg_rdata + {{(OFFSET_W-DISP_W){1'b0}}, addr_r[11:0]};
        state_nxt                = ST_IDLE;
      end

      // Load walk: read byte cnt, take in byte cnt-1, write a page every
      // fourth byte, high byte first.
      ST_LOAD: begin
        if (cnt_r != CNT_END) begin
          sram_addr = AW'({bank, cnt_r[5:0]});
          sram_re   = 1'b1;
        end
        if (cnt_r != '0) begin
          asm_nxt = {asm_r[15:0], sram_rdata};
          if (widx[1:0] == 2'd3) begin
            pg.we    = 1'b1;
            pg.idx   = widx[5:2];
            pg.wdata = {asm_r, sram_rdata};
          end
        end
        if (cnt_r == CNT_END) begin
          res_nxt.valid = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      // Store walk: read a page ahead, then write its four bytes.
      ST_STORE: begin
        if (cnt_r != CNT_END && cnt_r[1:0] == 2'd0) begin
          pg.re  = 1'b1;
          pg.idx = cnt_r[5:2];
        end
        if (cnt_r != '0) begin
          sram_addr = AW'({bank, widx});
          sram_we   = 1'b1;
          case (widx[1:0])
            2'd0: begin
              sram_wdata = pg_rdata[31:24];
              hold_nxt   = pg_rdata;
            end
            2'd1:    sram_wdata = hold_r[23:16];
            2'd2:    sram_wdata = hold_r[15:8];
            default: sram_wdata = hold_r[7:0];
          endcase
        end
        if (cnt_r == CNT_END) begin
          res_nxt.valid = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/paged_mapper_with_map_file_sram_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paged mapper with map file SRAM
// Sixteen-page logical to physical address mapper with a byte SRAM holding
// eight map files that load or store the page offsets.
// ----------------------------------------------------------------------------
//
// Channel   Ports                                            Handshake
// request   in_operation, in_address, in_data               start, busy
// result    out_read_data, out_physical_address             out_valid strobe
//
// An SRAM write or an ignored control write sets its result in the execute
// state; SRAM reads and translations set it in a wait state after that, since
// each goes through one registered RAM read.
// A map file load or store walks 64 SRAM bytes through the single SRAM port
// before it strobes its result.
// After reset a clearing pass zeroes the SRAM and page table with busy high.
// Busy drops in the cycle the result is strobed, so a new request can be
// taken then. The receiver cannot stall a result.
// ----------------------------------------------------------------------------
module paged_mapper_with_map_file_sram_top
  import pmap_pkg::*;
#(
  parameter int SRAM_BYTES = SRAM_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_operation,
  input  logic [15:0]         in_address,
  input  logic [7:0]          in_data,
  output logic                out_valid,
  output logic [7:0]          out_read_data,
  output logic [OFFSET_W-1:0] out_physical_address
);

  localparam int AW = $clog2(SRAM_BYTES);

  res_t                res;
  pg_req_t             pg;
  logic [OFFSET_W-1:0] pg_rdata;
  logic [AW-1:0]       sram_addr;
  logic                sram_we;
  logic                sram_re;
  logic [7:0]          sram_wdata;
  logic [7:0]          sram_rdata;

  // Request sequencer.
  pmap_seq #(
    .SRAM_BYTES(SRAM_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_operation),
    .addr      (in_address),
    .data      (in_data),
    .busy      (busy),
    .res       (res),
    .sram_addr (sram_addr),
    .sram_we   (sram_we),
    .sram_re   (sram_re),
    .sram_wdata(sram_wdata),
    .sram_rdata(sram_rdata),
    .pg        (pg),
    .pg_rdata  (pg_rdata)
  );

  // Map file SRAM.
  pmap_ram #(
    .WIDTH(8),
    .DEPTH(SRAM_BYTES)
  ) u_sram (
    .clk  (clk),
    .we   (sram_we),
    .re   (sram_re),
    .addr (sram_addr),
    .wdata(sram_wdata),
    .rdata(sram_rdata)
  );

  // Page offset table.
  pmap_ram #(
    .WIDTH(OFFSET_W),
    .DEPTH(PAGE_COUNT)
  ) u_pages (
    .clk  (clk),
    .we   (pg.we),
    .re   (pg.re),
    .addr (pg.idx),
    .wdata(pg.wdata),
    .rdata(pg_rdata)
  );

  assign out_valid            = res.valid;
  assign out_read_data        = res.read_data;
  assign out_physical_address = res.physical_address;

  // Reset always starts the clearing pass.
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low after reset");

  // A taken request keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken without going busy");

  // Results never come back to back.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // The block is ready again while a result is shown.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while still busy");

endmodule
